// ===== sv/gls_pkg.sv =====
package gls_pkg;

    localparam int GLS_COORD_BITS = 16;
    localparam int GLS_MAX_STEPS  = 64;

    localparam int RATE_W   = 5;
    localparam int HEIGHT_W = 6;
    localparam int DLOG_W   = 3;
    localparam int HD_W     = HEIGHT_W + DLOG_W;

    localparam int RES_W     = 17;
    localparam int STRIDE_W  = 21;
    localparam int HI_W      = 17;
    localparam int M_DATA_W  = ((3 * STRIDE_W + 3 * HI_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TREE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE_LOG2 = 2'd2;

    localparam logic [RATE_W-1:0]   RATE_RESET   = 5'd2;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd0;
    localparam logic [DLOG_W-1:0]   DLOG_RESET   = 3'd1;
    localparam logic [RATE_W-1:0]   RATE_MIN     = 5'd2;

    localparam logic [RES_W-1:0]    FULL_RES   = 17'd65536;
    localparam logic [STRIDE_W-1:0] STRIDE_MAX = 21'h1FFFFF;

    typedef struct packed {
        logic [RATE_W-1:0]   rate;
        logic [HEIGHT_W-1:0] height;
        logic [DLOG_W-1:0]   dlog;
    } cfg_t;

endpackage

// ===== sv/gls_cfg.sv =====
module gls_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gls_pkg::CFG_DATA_W-1:0]    cfg_data,
    output gls_pkg::cfg_t                     cfg
);
    import gls_pkg::*;

    logic [RATE_W-1:0]   rate_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [DLOG_W-1:0]   dlog_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= RATE_RESET;
            height_reg <= HEIGHT_RESET;
            dlog_reg   <= DLOG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SPLIT_RATE:  rate_reg   <= cfg_data[RATE_W-1:0];
                REG_TREE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_DEGREE_LOG2: dlog_reg   <= cfg_data[DLOG_W-1:0];
                default: ;
            endcase
        end
    end

    // Rates of zero and one behave as two.
    assign cfg.rate   = (rate_reg < RATE_MIN) ? RATE_MIN : rate_reg;
    assign cfg.height = height_reg;
    assign cfg.dlog   = dlog_reg;

endmodule

// ===== sv/gls_div.sv =====
module gls_div #(
    parameter int DW = 17,
    parameter int SW = 21
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [SW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [SW-1:0] rem
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] div_reg, div_next;
    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DW-2:0], ge};
            rem_next = ge ? diff[SW-1:0] : trial[SW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/grid_level_stride_planner.sv =====
// One word in gives one word out. The block works on one extent at a time and
// holds s_tready low while it does. All division runs on a single bit-serial
// restoring divider that retires one quotient bit per cycle. Each split on the
// path takes one division, and the three strided upper bounds take one more
// division each. At most MAX_STEPS splits are taken, and never more than the
// axes allow. A finished word waits in the output register, and the next word
// is accepted while it waits. Configuration writes are taken in every cycle and
// are meant for when the block is idle.
module grid_level_stride_planner #(
    parameter int COORD_BITS = gls_pkg::GLS_COORD_BITS,
    parameter int MAX_STEPS  = gls_pkg::GLS_MAX_STEPS
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // Fields from bit 0: x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, resolution.
    input  logic [((6*COORD_BITS+17+7)/8)*8-1:0]        s_tdata,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // Fields from bit 0: x_stride, y_stride, z_stride, x_strided_hi,
    // y_strided_hi, z_strided_hi.
    output logic [gls_pkg::M_DATA_W-1:0]                m_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [gls_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [gls_pkg::CFG_DATA_W-1:0]              cfg_data
);
    import gls_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int SZW = CB + 2;
    localparam int TW  = (SZW > HI_W) ? SZW : HI_W;
    localparam int SCW = $clog2(MAX_STEPS + 1);
    localparam int PW  = HD_W + RES_W + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STOP   = 3'd1;
    localparam logic [2:0] ST_PICK   = 3'd2;
    localparam logic [2:0] ST_SPLIT  = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_FWAIT  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    cfg_t cfg;

    logic [2:0]                  state_reg;
    logic signed [CB-1:0]        lo_reg [3];
    logic signed [CB-1:0]        hi_reg [3];
    logic signed [DW-1:0]        dim_reg [3];
    logic [STRIDE_W-1:0]         stride_reg [3];
    logic [HI_W-1:0]             shi_reg [3];
    logic [RES_W-1:0]            res_reg;
    logic [HD_W-1:0]             hd_reg;
    logic [SCW-1:0]              stop_reg;
    logic [SCW-1:0]              step_reg;
    logic [1:0]                  pick_reg;
    logic [1:0]                  ax_reg;
    logic                        neg_reg;
    logic [M_DATA_W-1:0]         m_tdata_reg;
    logic                        m_tvalid_reg;

    logic                        s_accept;
    logic                        out_load;
    logic [RES_W-1:0]            res_in;
    logic [PW-1:0]               stop_full;
    logic [SCW-1:0]              stop_next;
    logic signed [DW-1:0]        rate_s;
    logic                        can_z, can_y, can_x, can_split;
    logic [1:0]                  pick_next;
    logic signed [SZW-1:0]       size_ax;
    logic [SZW-1:0]              mag_ax;
    logic                        div_start;
    logic [DW-1:0]               div_dividend;
    logic [STRIDE_W-1:0]         div_divisor;
    logic                        div_done;
    logic [DW-1:0]               div_quot;
    logic [STRIDE_W-1:0]         div_rem;
    logic [STRIDE_W+RATE_W-1:0]  stride_prod;
    logic [STRIDE_W-1:0]         stride_sat;
    logic signed [TW-1:0]        n_ax;
    logic signed [TW-1:0]        top_ax;

    gls_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gls_div #(
        .DW (DW),
        .SW (STRIDE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign res_in = s_tdata[6*CB +: RES_W];

    // Round half up of height * degree_log2 * (1 - resolution), capped.
    assign stop_full = PW'(hd_reg) * PW'(FULL_RES - res_reg) + PW'(32768);
    assign stop_next = (stop_full[PW-1:16] > (PW-16)'(MAX_STEPS)) ? SCW'(MAX_STEPS)
                                                               : stop_full[16 +: SCW];

    assign rate_s    = $signed(DW'(cfg.rate));
    assign can_z     = (dim_reg[2] >= dim_reg[1]) && (dim_reg[2] >= dim_reg[0])
                    && (dim_reg[2] >= rate_s);
    assign can_y     = (dim_reg[1] >= dim_reg[0]) && (dim_reg[1] >= rate_s);
    assign can_x     = (dim_reg[0] >= rate_s);
    assign can_split = (step_reg != stop_reg) && (can_z || can_y || can_x);
    assign pick_next = can_z ? AX_Z : (can_y ? AX_Y : AX_X);

    assign size_ax = SZW'(hi_reg[ax_reg]) - SZW'(lo_reg[ax_reg]) + SZW'(1);
    assign mag_ax  = size_ax[SZW-1] ? SZW'(-size_ax) : SZW'(size_ax);

    assign div_start    = ((state_reg == ST_PICK) && can_split) || (state_reg == ST_FIN);
    assign div_dividend = (state_reg == ST_FIN) ? mag_ax[DW-1:0]
                                                : $unsigned(dim_reg[pick_next]);
    assign div_divisor  = (state_reg == ST_FIN) ? stride_reg[ax_reg]
                                                : STRIDE_W'(cfg.rate);

    assign stride_prod = (STRIDE_W+RATE_W)'(stride_reg[pick_reg])
                       * (STRIDE_W+RATE_W)'(cfg.rate);
    assign stride_sat  = (stride_prod > (STRIDE_W+RATE_W)'(STRIDE_MAX))
                       ? STRIDE_MAX : stride_prod[STRIDE_W-1:0];

    assign n_ax   = neg_reg ? -$signed(TW'(div_quot))
                            : $signed(TW'(div_quot)) + TW'(div_rem != '0);
    assign top_ax = TW'(lo_reg[ax_reg]) + n_ax - TW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_STOP;
                    end
                end
                ST_STOP: state_reg <= ST_PICK;
                ST_PICK: state_reg <= can_split ? ST_SPLIT : ST_FIN;
                ST_SPLIT: begin
                    if (div_done) begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_FIN: state_reg <= ST_FWAIT;
                ST_FWAIT: begin
                    if (div_done) begin
                        state_reg <= (ax_reg == AX_Z) ? ST_OUT : ST_FIN;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    for (int a = 0; a < 3; a++) begin
                        lo_reg[a]     <= $signed(s_tdata[2*a*CB +: CB]);
                        hi_reg[a]     <= $signed(s_tdata[(2*a+1)*CB +: CB]);
                        dim_reg[a]    <= DW'($signed(s_tdata[(2*a+1)*CB +: CB]))
                                       - DW'($signed(s_tdata[2*a*CB +: CB]));
                        stride_reg[a] <= STRIDE_W'(1);
                    end
                    res_reg <= (res_in > FULL_RES) ? FULL_RES : res_in;
                    hd_reg  <= HD_W'(cfg.height) * HD_W'(cfg.dlog);
                end
            end
            ST_STOP: begin
                stop_reg <= stop_next;
                step_reg <= '0;
            end
            ST_PICK: begin
                pick_reg <= pick_next;
                ax_reg   <= AX_X;
            end
            ST_SPLIT: begin
                if (div_done) begin
                    dim_reg[pick_reg]    <= $signed(div_quot) + DW'(div_rem != '0);
                    stride_reg[pick_reg] <= stride_sat;
                    step_reg             <= step_reg + 1'b1;
                end
            end
            ST_FIN: begin
                neg_reg <= size_ax[SZW-1];
            end
            ST_FWAIT: begin
                if (div_done) begin
                    shi_reg[ax_reg] <= top_ax[HI_W-1:0];
                    ax_reg          <= ax_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= M_DATA_W'({shi_reg[2], shi_reg[1], shi_reg[0],
                                              stride_reg[2], stride_reg[1],
                                              stride_reg[0]});
                end
            end
            default: ;
        endcase
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== sv/gls_checker.sv =====
module gls_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gls_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic                          cfg_ready
);
    import gls_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Output word changed while stalled.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted again while a word was in work.");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("Result appeared without work in progress.");

    a_stride_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STRIDE_W-1:0] != '0)
                  && (m_tdata[2*STRIDE_W-1:STRIDE_W] != '0)
                  && (m_tdata[3*STRIDE_W-1:2*STRIDE_W] != '0))
        else $error("Zero stride in output word.");

    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> cfg_ready)
        else $error("Configuration channel not ready.");

endmodule

bind grid_level_stride_planner gls_checker u_gls_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_ready (cfg_ready)
);
